>>> rtl/nsf_pkg.sv
// shared constants, types and table functions of the nmea sentence framer
package nsf_pkg;

  localparam int NSF_NAME_TABLE = 7;
  localparam int NSF_NAME_LEN   = 5;
  localparam int NSF_NAME_COUNT = 7;
  localparam int NSF_NAME_BITS  = NSF_NAME_LEN * 8;

  // name 0 sits in the low bits, first character of each name in its top byte
  localparam logic [NSF_NAME_TABLE*NSF_NAME_BITS-1:0] NSF_NAME_ROM =
    {"GPZDA", "GPVTG", "GPRMC", "GPGSV", "GPGSA", "GPGLL", "GPGGA"};

  localparam logic [7:0] NSF_CH_DOLLAR = 8'h24;
  localparam logic [7:0] NSF_CH_STAR   = 8'h2A;
  localparam logic [7:0] NSF_CH_COMMA  = 8'h2C;
  localparam logic [7:0] NSF_CH_CR     = 8'h0D;
  localparam logic [7:0] NSF_CH_LF     = 8'h0A;
  localparam logic [7:0] NSF_CH_SPACE  = 8'h20;
  localparam logic [7:0] NSF_CH_TILDE  = 8'h7E;
  localparam logic [7:0] NSF_CH_ZERO   = 8'h30;
  localparam logic [7:0] NSF_CH_LA     = 8'h61;
  localparam logic [7:0] NSF_CH_LFH    = 8'h66;
  localparam logic [7:0] NSF_CASE_BIT  = 8'h20;
  localparam logic [7:0] NSF_NIB_MASK  = 8'h0F;

  typedef enum logic [1:0] {
    NSF_ST_OK   = 2'd0,
    NSF_ST_BAD  = 2'd1,
    NSF_ST_DONE = 2'd2
  } nsf_status_t;

  // outcome of one name compare step
  typedef struct packed {
    logic hit;
    logic comma_end;
    logic prefix_ok;
  } nsf_match_t;

  // character of a fixed name, zero past the end or past the table
  function automatic logic [7:0] nsf_name_char(input logic [2:0] idx, input logic [7:0] pos);
    int base;
    base = 0;
    if (idx >= 3'(NSF_NAME_TABLE) || pos >= 8'(NSF_NAME_LEN)) begin
      return 8'h00;
    end
    base = int'(idx) * NSF_NAME_BITS + (NSF_NAME_LEN - 1 - int'(pos)) * 8;
    return NSF_NAME_ROM[base +: 8];
  endfunction

  // hex digit value, lower case accepted, other characters wrap
  function automatic logic [7:0] nsf_hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = c | NSF_CASE_BIT;
    if (v >= NSF_CH_LA && v <= NSF_CH_LFH) begin
      return v - NSF_CH_LA + 8'd10;
    end
    return v - NSF_CH_ZERO;
  endfunction

endpackage

>>> rtl/nsf_name_cmp.sv
// shared name compare unit: one candidate name against one character
module nsf_name_cmp import nsf_pkg::*; (
  input  logic [2:0] idx_i,
  input  logic [7:0] pos_i,
  input  logic [7:0] char_i,
  output nsf_match_t match_o
);

  logic [7:0] ref_c;
  logic [2:0] idx_next;

  assign idx_next = idx_i + 3'd1;

  always_comb begin
    ref_c = nsf_name_char(idx_i, pos_i);
    match_o.hit       = (char_i == ref_c);
    match_o.comma_end = (char_i == NSF_CH_COMMA) && (ref_c == 8'h00);
    match_o.prefix_ok = 1'b1;
    // matched prefix of the next name must equal that of this one
    for (int j = 0; j < NSF_NAME_LEN; j++) begin
      if (8'(j) < pos_i &&
          nsf_name_char(idx_i, 8'(j)) != nsf_name_char(idx_next, 8'(j))) begin
        match_o.prefix_ok = 1'b0;
      end
    end
  end

endmodule

>>> rtl/nmea_sentence_framer.sv
// top level of the nmea sentence framer: sequencer, sentence state and result register
//
// usage
// - input channel in_valid/in_ready/in_rx_char carries one received byte per word
// - result channel out_valid/out_ready carries exactly one result word per input word:
//   status, sentence type, field number, position in field and name-done flag
// - a '$' always restarts a sentence; '*' is followed by two hex checksum digits,
//   cr or lf ends a sentence without checksum; bad characters abort
// - while the sentence name is received each character is matched against the
//   fixed names, one candidate name per cycle on the shared compare unit
// - timing: a word is taken in the ready state and decoded in the cycle after; name
//   characters then go on to the search state, which tries the candidate names in turn
// - the result appears on out_* the cycle after the decode or the last search step
// - in_ready is high only while the sequencer waits for a word; it does not wait
//   for the previous result to be taken
// - if the receiver stalls, a finished word waits in the output register and the
//   next word holds in its last step until the register frees up
// - reset (rst_n low, synchronous) returns to the idle phase with a cleared
//   checksum, sentence and counters, and drops out_valid
module nmea_sentence_framer import nsf_pkg::*; #(
  parameter int NAME_COUNT = NSF_NAME_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [2:0] out_sentence,
  output logic [7:0] out_field_number,
  output logic [7:0] out_field_pos,
  output logic       out_name_done
);

  // names beyond the table do not exist
  localparam int NAME_LIM = (NAME_COUNT < NSF_NAME_TABLE) ? NAME_COUNT : NSF_NAME_TABLE;
  localparam logic [3:0] LIM4 = 4'(NAME_LIM);

  typedef enum logic [1:0] {
    S_READY,
    S_EXEC,
    S_SEARCH
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_CK1,
    PH_CK2
  } phase_t;

  state_t      st_r, st_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [2:0]  sid_r, sid_nxt;
  logic [7:0]  fcnt_r, fcnt_nxt;
  logic [7:0]  ccnt_r, ccnt_nxt;
  logic [7:0]  char_r, char_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [2:0]  out_sentence_r, out_sentence_nxt;
  logic [7:0]  out_fnum_r, out_fnum_nxt;
  logic [7:0]  out_fpos_r, out_fpos_nxt;
  logic        out_done_r, out_done_nxt;

  nsf_match_t  match;
  nsf_status_t res_status;
  logic        res_done;
  logic        out_load;
  logic        slot_free;
  logic [2:0]  start_idx;
  logic        start_out;
  logic        last_name;
  logic        printable;
  logic        is_comma;
  logic [7:0]  xor_upd;
  logic [7:0]  fcnt_upd;
  logic [7:0]  ccnt_upd;
  logic [7:0]  hex_v;

  // shared compare unit, walked over the candidate names by the sequencer
  nsf_name_cmp u_cmp (
    .idx_i  (idx_r),
    .pos_i  (ccnt_r),
    .char_i (char_r),
    .match_o(match)
  );

  assign in_ready  = (st_r == S_READY);
  assign slot_free = !out_valid_r || out_ready;

  // search starts at the current candidate
  assign start_idx = (sid_r == 3'd0) ? 3'd0 : sid_r - 3'd1;
  assign start_out = ({1'b0, start_idx} >= LIM4);
  assign last_name = ({1'b0, idx_r} + 4'd1 >= LIM4);

  assign printable = (char_r >= NSF_CH_SPACE) && (char_r <= NSF_CH_TILDE);
  assign is_comma  = (char_r == NSF_CH_COMMA);
  assign xor_upd   = xor_r ^ char_r;
  assign hex_v     = nsf_hex_val(char_r);

  // data characters still move the counters when they abort
  assign fcnt_upd = (is_comma && fcnt_r != 8'hFF) ? fcnt_r + 8'd1 : fcnt_r;
  assign ccnt_upd = is_comma ? 8'd0 : ((ccnt_r == 8'hFF) ? ccnt_r : ccnt_r + 8'd1);

  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    xor_nxt       = xor_r;
    sid_nxt       = sid_r;
    fcnt_nxt      = fcnt_r;
    ccnt_nxt      = ccnt_r;
    char_nxt      = char_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_status    = NSF_ST_OK;
    res_done      = 1'b0;
    out_load      = 1'b0;

    case (st_r)
      S_READY: begin
        if (in_valid) begin
          char_nxt = in_rx_char;
          st_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        if (char_r != NSF_CH_DOLLAR && phase_r == PH_DATA && char_r != NSF_CH_STAR &&
            char_r != NSF_CH_CR && char_r != NSF_CH_LF && printable &&
            fcnt_r == 8'd0 && !start_out) begin
          // name character: hand over to the search loop
          idx_nxt = start_idx;
          st_nxt  = S_SEARCH;
        end else if (slot_free) begin
          st_nxt   = S_READY;
          out_load = 1'b1;
          if (char_r == NSF_CH_DOLLAR) begin
            xor_nxt   = 8'd0;
            sid_nxt   = 3'd0;
            fcnt_nxt  = 8'd0;
            ccnt_nxt  = 8'd0;
            phase_nxt = PH_DATA;
          end else begin
            case (phase_r)
              PH_IDLE: begin
                res_status = NSF_ST_BAD;
                sid_nxt    = 3'd0;
              end
              PH_DATA: begin
                if (char_r == NSF_CH_STAR) begin
                  phase_nxt = PH_CK1;
                end else if (char_r == NSF_CH_CR || char_r == NSF_CH_LF) begin
                  phase_nxt  = PH_IDLE;
                  res_status = NSF_ST_DONE;
                end else if (!printable) begin
                  phase_nxt  = PH_IDLE;
                  sid_nxt    = 3'd0;
                  res_status = NSF_ST_BAD;
                end else begin
                  xor_nxt  = xor_upd;
                  fcnt_nxt = fcnt_upd;
                  ccnt_nxt = ccnt_upd;
                  // name with no candidate left, or later field of an unknown sentence
                  if (fcnt_r == 8'd0 || sid_r == 3'd0) begin
                    phase_nxt  = PH_IDLE;
                    sid_nxt    = 3'd0;
                    res_status = NSF_ST_BAD;
                  end
                end
              end
              PH_CK1: begin
                if ((xor_r >> 4) != hex_v) begin
                  phase_nxt  = PH_IDLE;
                  sid_nxt    = 3'd0;
                  res_status = NSF_ST_BAD;
                end else begin
                  phase_nxt = PH_CK2;
                end
              end
              PH_CK2: begin
                if ((xor_r & NSF_NIB_MASK) != hex_v) begin
                  phase_nxt  = PH_IDLE;
                  sid_nxt    = 3'd0;
                  res_status = NSF_ST_BAD;
                end else begin
                  phase_nxt  = PH_IDLE;
                  res_status = NSF_ST_DONE;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
      end

      S_SEARCH: begin
        if (match.hit || match.comma_end || last_name || !match.prefix_ok) begin
          if (slot_free) begin
            st_nxt   = S_READY;
            out_load = 1'b1;
            xor_nxt  = xor_upd;
            fcnt_nxt = fcnt_upd;
            ccnt_nxt = ccnt_upd;
            if (match.hit) begin
              sid_nxt = idx_r + 3'd1;
            end else if (match.comma_end) begin
              sid_nxt  = start_idx + 3'd1;
              res_done = 1'b1;
            end else begin
              // candidates exhausted or prefix differs
              phase_nxt  = PH_IDLE;
              sid_nxt    = 3'd0;
              res_status = NSF_ST_BAD;
            end
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end

      default: begin
        st_nxt = S_READY;
      end
    endcase

    out_status_nxt   = out_status_r;
    out_sentence_nxt = out_sentence_r;
    out_fnum_nxt     = out_fnum_r;
    out_fpos_nxt     = out_fpos_r;
    out_done_nxt     = out_done_r;
    if (out_load) begin
      out_valid_nxt    = 1'b1;
      out_status_nxt   = res_status;
      out_sentence_nxt = sid_nxt;
      out_fnum_nxt     = fcnt_nxt;
      out_fpos_nxt     = ccnt_nxt;
      out_done_nxt     = res_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_READY;
      phase_r     <= PH_IDLE;
      xor_r       <= 8'd0;
      sid_r       <= 3'd0;
      fcnt_r      <= 8'd0;
      ccnt_r      <= 8'd0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      xor_r       <= xor_nxt;
      sid_r       <= sid_nxt;
      fcnt_r      <= fcnt_nxt;
      ccnt_r      <= ccnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    char_r         <= char_nxt;
    out_status_r   <= out_status_nxt;
    out_sentence_r <= out_sentence_nxt;
    out_fnum_r     <= out_fnum_nxt;
    out_fpos_r     <= out_fpos_nxt;
    out_done_r     <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_sentence     = out_sentence_r;
  assign out_field_number = out_fnum_r;
  assign out_field_pos    = out_fpos_r;
  assign out_name_done    = out_done_r;

  // a new result only comes from a decode or a final search step
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == S_EXEC || $past(st_r) == S_SEARCH))
    else $error("result loaded outside decode or search");

  // a completed sentence leaves the framer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == NSF_ST_DONE) |-> (phase_r == PH_IDLE))
    else $error("completed sentence but framer not idle");

  // an aborted or rejected character never reports a sentence type
  a_bad_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == NSF_ST_BAD) |-> (out_sentence_r == 3'd0))
    else $error("abort with sentence type set");

  // the name ends on its comma: first field closed, position cleared
  a_name_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |->
      (out_status_r == NSF_ST_OK && out_fnum_r == 8'd1 && out_fpos_r == 8'd0))
    else $error("name done flag inconsistent");

  // the search never walks past the last name
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SEARCH) |-> ({1'b0, idx_r} < LIM4))
    else $error("name search index out of range");

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the nmea sentence framer with its own framing predictor
module testbench;
  import nsf_pkg::*;

  // search stops after the last name of the table, or earlier if the name count is smaller
  localparam int NAME_LIMIT = (NSF_NAME_COUNT < NSF_NAME_TABLE) ? NSF_NAME_COUNT : NSF_NAME_TABLE;
  localparam int ROW_COUNT = 28;
  localparam int RANDOM_WORDS = 1500;
  localparam int CALM_WORDS = 200;        // closing stretch with no idling on either side
  localparam int TAIL_CYCLES = 16;        // beyond the worst name search plus output register
  localparam int DRAIN_LIMIT = 20000;
  localparam int WATCHDOG_TIME = 1000000;

  // one result word as the block should present it
  typedef struct packed {
    nsf_status_t status;
    logic [2:0]  sentence;
    logic [7:0]  field_number;
    logic [7:0]  field_pos;
    logic        name_done;
  } framer_result_t;

  // one row of the directed part; the result is only taken from the row when typed is set
  typedef struct packed {
    logic [7:0]     ch;
    logic           typed;
    framer_result_t res;
  } stim_row_t;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_DATA,
    PHASE_CK_HI,
    PHASE_CK_LO
  } frame_phase_t;

  typedef enum int {
    SHAPE_PLAIN,
    SHAPE_LONG_FIELD,
    SHAPE_MANY_FIELDS
  } sentence_shape_t;

  localparam framer_result_t RES_CLEAR = '{NSF_ST_OK, 3'd0, 8'd0, 8'd0, 1'b0};
  localparam framer_result_t RES_BAD = '{NSF_ST_BAD, 3'd0, 8'd0, 8'd0, 1'b0};
  localparam logic [8*12-1:0] NAME_LETTERS = "GPRMZVTDSLAX";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_char = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [2:0] out_sentence;
  logic [7:0] out_field_number;
  logic [7:0] out_field_pos;
  logic       out_name_done;

  // the seven fixed names, first character in the top byte
  logic [8*NSF_NAME_LEN-1:0] known_names [NSF_NAME_TABLE] =
    '{"GPGGA", "GPGLL", "GPGSA", "GPGSV", "GPRMC", "GPVTG", "GPZDA"};

  // directed part: reset behaviour, extremes, checksum with lower case, abort paths
  stim_row_t directed_rows [ROW_COUNT] = '{
    '{"A",           1'b1, RES_BAD},    // idle char straight after reset
    '{8'h00,         1'b1, RES_BAD},    // lowest byte while idle
    '{8'hFF,         1'b1, RES_BAD},    // highest byte while idle
    '{NSF_CH_DOLLAR, 1'b1, RES_CLEAR},
    '{"G",           1'b0, RES_CLEAR},
    '{"P",           1'b0, RES_CLEAR},
    '{"V",           1'b0, RES_CLEAR},
    '{"T",           1'b0, RES_CLEAR},
    '{"G",           1'b0, RES_CLEAR},
    '{NSF_CH_COMMA,  1'b0, RES_CLEAR},  // ends a recognised name
    '{NSF_CH_STAR,   1'b0, RES_CLEAR},
    '{"7",           1'b0, RES_CLEAR},
    '{"e",           1'b0, RES_CLEAR},  // lower case digit completes the sentence
    '{NSF_CH_DOLLAR, 1'b1, RES_CLEAR},
    '{NSF_CH_STAR,   1'b1, RES_CLEAR},
    '{"1",           1'b1, RES_BAD},    // checksum of an empty sentence is zero
    '{NSF_CH_DOLLAR, 1'b1, RES_CLEAR},
    '{"G",           1'b0, RES_CLEAR},
    '{"P",           1'b0, RES_CLEAR},
    '{"G",           1'b0, RES_CLEAR},
    '{"X",           1'b0, RES_CLEAR},  // no name carries this prefix
    '{NSF_CH_DOLLAR, 1'b1, RES_CLEAR},
    '{"G",           1'b0, RES_CLEAR},
    '{8'h7F,         1'b0, RES_CLEAR},  // just above tilde
    '{NSF_CH_DOLLAR, 1'b1, RES_CLEAR},
    '{"G",           1'b0, RES_CLEAR},
    '{NSF_CH_LF,     1'b0, RES_CLEAR},  // line end while the name is incomplete
    '{"A",           1'b0, RES_CLEAR}   // idle after completion clears the sentence
  };

  // predictor state
  frame_phase_t fr_phase = PHASE_IDLE;
  logic [7:0]   fr_xor = 8'h00;
  logic [2:0]   fr_sentence = 3'd0;
  logic [7:0]   fr_fields = 8'h00;
  logic [7:0]   fr_pos = 8'h00;

  framer_result_t pending_results [$];
  bit gaps_on = 1'b1;
  int stall_left = 0;
  int word_count = 0;
  int result_count = 0;
  int done_count = 0;
  int bad_count = 0;
  int name_end_count = 0;
  int sentence_count = 0;
  int fail_count = 0;

  nmea_sentence_framer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_char       (in_rx_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_sentence     (out_sentence),
    .out_field_number (out_field_number),
    .out_field_pos    (out_field_pos),
    .out_name_done    (out_name_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // character of a fixed name, zero past its end
  function automatic logic [7:0] known_name_char(input int idx, input int pos);
    if (idx >= NSF_NAME_TABLE || pos >= NSF_NAME_LEN) return 8'h00;
    return known_names[idx][8*(NSF_NAME_LEN-1-pos) +: 8];
  endfunction

  // value of a checksum digit: letters a..f either case, everything else wraps from '0'
  function automatic logic [7:0] digit_value(input logic [7:0] ch);
    logic [7:0] folded;
    folded = ch | NSF_CASE_BIT;
    if (folded >= NSF_CH_LA && folded <= NSF_CH_LFH) return folded - NSF_CH_LA + 8'd10;
    return folded - NSF_CH_ZERO;
  endfunction

  // one step of the name search, from the current candidate onwards
  function automatic nsf_status_t search_name(input logic [7:0] ch);
    int idx;
    int j;
    int pos;
    int start;
    logic [7:0] rc;
    pos = int'(fr_pos);
    start = (fr_sentence == 3'd0) ? 0 : int'(fr_sentence) - 1;
    for (idx = start; idx < NAME_LIMIT; idx++) begin
      rc = known_name_char(idx, pos);
      if (ch == rc) begin
        fr_sentence = 3'(idx + 1);
        return NSF_ST_OK;
      end
      if (ch == NSF_CH_COMMA && rc == 8'h00) begin
        fr_sentence = 3'(start + 1);
        return NSF_ST_DONE;
      end
      if (idx + 1 >= NAME_LIMIT) return NSF_ST_BAD;
      // give up as soon as the next name no longer shares the matched prefix
      for (j = 0; j < pos && j < NSF_NAME_LEN; j++) begin
        if (known_name_char(idx, j) != known_name_char(idx + 1, j)) return NSF_ST_BAD;
      end
    end
    return NSF_ST_BAD;
  endfunction

  // advance the predictor by one received character and give the result word it causes
  function automatic framer_result_t predict_framer(input logic [7:0] ch);
    framer_result_t res;
    nsf_status_t st;
    logic name_end;
    st = NSF_ST_OK;
    name_end = 1'b0;
    if (ch == NSF_CH_DOLLAR) begin
      // a start char restarts from any phase
      fr_xor = 8'h00;
      fr_sentence = 3'd0;
      fr_fields = 8'h00;
      fr_pos = 8'h00;
      fr_phase = PHASE_DATA;
    end else if (fr_phase == PHASE_IDLE) begin
      st = NSF_ST_BAD;
      fr_sentence = 3'd0;
    end else if (fr_phase == PHASE_DATA) begin
      if (ch == NSF_CH_STAR) begin
        fr_phase = PHASE_CK_HI;
      end else if (ch == NSF_CH_CR || ch == NSF_CH_LF) begin
        fr_phase = PHASE_IDLE;
        st = NSF_ST_DONE;
      end else if (ch < NSF_CH_SPACE || ch > NSF_CH_TILDE) begin
        fr_phase = PHASE_IDLE;
        fr_sentence = 3'd0;
        st = NSF_ST_BAD;
      end else begin
        fr_xor = fr_xor ^ ch;
        if (fr_fields == 8'h00) begin
          st = search_name(ch);
          if (st == NSF_ST_DONE) begin
            name_end = 1'b1;
            st = NSF_ST_OK;
          end else if (st == NSF_ST_BAD) begin
            fr_phase = PHASE_IDLE;
            fr_sentence = 3'd0;
          end
        end else if (fr_sentence == 3'd0) begin
          fr_phase = PHASE_IDLE;
          st = NSF_ST_BAD;
        end
        // the counters move even on the char that aborts
        if (ch == NSF_CH_COMMA) begin
          if (fr_fields != 8'hFF) fr_fields = fr_fields + 8'd1;
          fr_pos = 8'h00;
        end else if (fr_pos != 8'hFF) begin
          fr_pos = fr_pos + 8'd1;
        end
      end
    end else if (fr_phase == PHASE_CK_HI) begin
      if ({4'h0, fr_xor[7:4]} != digit_value(ch)) begin
        fr_phase = PHASE_IDLE;
        fr_sentence = 3'd0;
        st = NSF_ST_BAD;
      end else begin
        fr_phase = PHASE_CK_LO;
      end
    end else begin
      if ({4'h0, fr_xor[3:0]} != digit_value(ch)) begin
        fr_phase = PHASE_IDLE;
        fr_sentence = 3'd0;
        st = NSF_ST_BAD;
      end else begin
        fr_phase = PHASE_IDLE;
        st = NSF_ST_DONE;
      end
    end
    res.status = st;
    res.sentence = fr_sentence;
    res.field_number = fr_fields;
    res.field_pos = fr_pos;
    res.name_done = name_end;
    return res;
  endfunction

  // offer one word, wait for the handshake, then queue what it should produce
  task automatic send_word(input logic [7:0] ch, input logic typed, input framer_result_t res);
    framer_result_t predicted;
    int gap;
    gap = 0;
    // closing stretch runs with no idling, whatever sentence is in progress
    if (word_count >= ROW_COUNT + RANDOM_WORDS - CALM_WORDS) gaps_on = 1'b0;
    if (gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_char <= ch;
    do @(posedge clk); while (!in_ready);
    // the predictor runs on every word so its state stays in step with typed rows
    predicted = predict_framer(ch);
    pending_results.push_back(typed ? res : predicted);
    word_count++;
  endtask

  // printable field char other than the framing characters
  function automatic logic [7:0] field_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(NSF_CH_SPACE, NSF_CH_TILDE));
    while (ch == NSF_CH_DOLLAR || ch == NSF_CH_STAR || ch == NSF_CH_COMMA);
    return ch;
  endfunction

  // checksum digit for one nibble, either case, sometimes a punctuation alias or spoilt
  function automatic logic [7:0] checksum_digit(input logic [3:0] nib, input bit spoil);
    logic [3:0] n;
    n = nib;
    if (spoil) begin
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      n = nib ^ 4'($urandom_range(1, 15));
    end else if (nib >= 4'd10 && $urandom_range(0, 3) == 0) begin
      // ':' to '?' decode like the letters a to f
      return 8'h3A + 8'(nib - 4'd10);
    end
    if (n < 4'd10) return NSF_CH_ZERO + 8'(n);
    return ($urandom_range(0, 1) ? NSF_CH_LA : 8'h41) + 8'(n - 4'd10);
  endfunction

  // one random sentence: mostly well formed, with noise, broken names and bad digits mixed in
  task automatic send_sentence(input sentence_shape_t shape);
    logic [7:0] ck;
    logic [7:0] ch;
    int nfields;
    int flen;
    int f;
    int p;
    int k;
    int ending;
    bit plain;
    plain = (shape == SHAPE_PLAIN);
    if (plain && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0, RES_CLEAR);
    end
    send_word(NSF_CH_DOLLAR, 1'b0, RES_CLEAR);
    ck = 8'h00;
    if (!plain || $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, NSF_NAME_TABLE - 1);
      for (p = 0; p < NSF_NAME_LEN; p++) begin
        ch = known_name_char(k, p);
        ck = ck ^ ch;
        send_word(ch, 1'b0, RES_CLEAR);
      end
    end else begin
      // made-up name from letters of the real names plus X
      repeat ($urandom_range(1, 6)) begin
        k = $urandom_range(0, 11);
        ch = NAME_LETTERS[8*k +: 8];
        ck = ck ^ ch;
        send_word(ch, 1'b0, RES_CLEAR);
      end
    end
    case (shape)
      SHAPE_MANY_FIELDS: nfields = 260;
      SHAPE_LONG_FIELD:  nfields = 1;
      default:           nfields = $urandom_range(0, 6);
    endcase
    for (f = 0; f < nfields; f++) begin
      ck = ck ^ NSF_CH_COMMA;
      send_word(NSF_CH_COMMA, 1'b0, RES_CLEAR);
      flen = (shape == SHAPE_LONG_FIELD) ? 270 : $urandom_range(0, 8);
      for (p = 0; p < flen; p++) begin
        ch = field_char();
        if (plain && $urandom_range(0, 39) == 0) ch = 8'($urandom_range(0, 255));
        ck = ck ^ ch;
        send_word(ch, 1'b0, RES_CLEAR);
      end
    end
    ending = $urandom_range(0, 9);
    if (ending <= 5) begin
      send_word(NSF_CH_STAR, 1'b0, RES_CLEAR);
      send_word(checksum_digit(ck[7:4], $urandom_range(0, 15) == 0), 1'b0, RES_CLEAR);
      send_word(checksum_digit(ck[3:0], $urandom_range(0, 15) == 0), 1'b0, RES_CLEAR);
    end else if (ending <= 7) begin
      send_word(NSF_CH_CR, 1'b0, RES_CLEAR);
    end else if (ending == 8) begin
      send_word(NSF_CH_LF, 1'b0, RES_CLEAR);
    end
    // otherwise the sentence is cut off and the next start char takes over
    sentence_count++;
  endtask

  task automatic compare_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      fail_count++;
    end
  endtask

  // compare one taken result word with the oldest prediction
  task automatic check_result();
    framer_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word taken with no prediction pending");
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status", 8'(want.status), 8'(out_status));
      compare_field("sentence", 8'(want.sentence), 8'(out_sentence));
      compare_field("field_number", want.field_number, out_field_number);
      compare_field("field_pos", want.field_pos, out_field_pos);
      compare_field("name_done", 8'(want.name_done), 8'(out_name_done));
      result_count++;
      if (want.status == NSF_ST_DONE) done_count++;
      if (want.status == NSF_ST_BAD) bad_count++;
      if (want.name_done) name_end_count++;
    end
  endtask

  // result side: take words and stall in random bursts while gaps are enabled
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // input side: reset, directed table, random sentences, then drain
  initial begin
    int i;
    int drain_cycles;
    sentence_shape_t shape;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < ROW_COUNT; i++) begin
      send_word(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].res);
    end
    // one saturating field and one saturating field count early on, the rest plain
    while (word_count < ROW_COUNT + RANDOM_WORDS) begin
      if (sentence_count == 2) shape = SHAPE_LONG_FIELD;
      else if (sentence_count == 5) shape = SHAPE_MANY_FIELDS;
      else shape = SHAPE_PLAIN;
      send_sentence(shape);
    end
    gaps_on = 1'b0;
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted result words never arrived", pending_results.size());
      fail_count++;
    end
    $display("checked %0d result words from %0d random sentences and the directed table",
             result_count, sentence_count);
    $display("%0d sentences completed, %0d words rejected or aborting, %0d name ends seen",
             done_count, bad_count, name_end_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop if the handshakes ever hang
  initial begin
    #(WATCHDOG_TIME);
    $display("FAILURE");
    $finish;
  end

endmodule
